### hw/rtl/report_framer_crc32_unit_defines.svh
// Assertion macros shared by the report framer RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef REPORT_FRAMER_CRC32_UNIT_DEFINES_SVH
`define REPORT_FRAMER_CRC32_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check that expr holds at every clock edge outside reset
`define RFC_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("rfc: assertion failed");
// Check that cons holds in the cycle after ante
`define RFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rfc: assertion failed");
`else
`define RFC_ASSERT(label, expr)
`define RFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/rfc_pkg.sv
// Package for the report framer: frame geometry, CRC-32 constants and step,
// register indexes and the types passed between front, queue and back.
package rfc_pkg;

   localparam int PAYLOAD_LEN  = 47;
   localparam int FRAME_LEN    = 78;
   localparam int DATA_LEN     = FRAME_LEN - 4;
   localparam int PAYLOAD_ROOM = DATA_LEN - 3;
   localparam int PAD_LEN      = (DATA_LEN - 3 - PAYLOAD_LEN > 0) ?
                                 (DATA_LEN - 3 - PAYLOAD_LEN) : 0;
   localparam int PAD_LAST     = (PAD_LEN > 0) ? (PAD_LEN - 1) : 0;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 7;
   localparam int CNT_W     = 7;
   localparam int SEQ_W     = 4;
   localparam int CRC_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REPORT_ID  = 2'd0,
      CSR_HEADER_TAG = 2'd1,
      CSR_CRC_SEED   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_PAYLOAD,
      PH_PAD,
      PH_TRAILER
   } phase_type;

   // One classified input transaction
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              first;
      logic              emit;
      logic              last;
      logic [BYTE_W-1:0] report_id;
      logic [BYTE_W-1:0] header_tag;
      logic [SEQ_W-1:0]  seq;
      logic [CRC_W-1:0]  crc_start;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Reflected CRC-32 over one byte, LSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hw/rtl/rfc_front.sv
// Front of the report framer: configuration registers, payload position and
// sequence count; classifies each input transaction. Depends on rfc_pkg.
module rfc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [rfc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfc_pkg::BYTE_W-1:0]       csr_data,
   input  logic                             req_valid,
   input  logic [rfc_pkg::BYTE_W-1:0]       req_payload_byte,
   output logic                             req_stall,
   input  rfc_pkg::queue_status_type        q_status,
   output logic                             push,
   output rfc_pkg::item_type                push_item
);
   import rfc_pkg::*;

   logic [BYTE_W-1:0] report_id_ff, report_id_in;
   logic [BYTE_W-1:0] header_tag_ff, header_tag_in;
   logic [BYTE_W-1:0] crc_seed_ff, crc_seed_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;

   logic             accept;
   logic             first;
   logic             emit;
   logic             last;
   logic [POS_W-1:0] pos_next;

   // Register writes
   always_comb begin
      report_id_in  = report_id_ff;
      header_tag_in = header_tag_ff;
      crc_seed_in   = crc_seed_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_REPORT_ID:  report_id_in  = csr_data;
            CSR_HEADER_TAG: header_tag_in = csr_data;
            CSR_CRC_SEED:   crc_seed_in   = csr_data;
            default:        ;
         endcase
      end
   end

   // Classify the transaction by its place in the frame
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign first     = (pos_ff == '0);
   assign emit      = (pos_ff < POS_W'(PAYLOAD_ROOM));
   assign pos_next  = pos_ff + 1'b1;
   assign last      = (pos_next >= POS_W'(PAYLOAD_LEN));

   assign pos_in = accept ? (last ? '0 : pos_next) : pos_ff;
   assign seq_in = (accept && first) ? seq_ff + 1'b1 : seq_ff;

   // Drop transactions that produce no frame byte
   assign push = accept && (first || emit || last);

   always_comb begin
      push_item            = '0;
      push_item.data       = req_payload_byte;
      push_item.first      = first;
      push_item.emit       = emit;
      push_item.last       = last;
      push_item.report_id  = report_id_ff;
      push_item.header_tag = header_tag_ff;
      push_item.seq        = seq_ff;
      push_item.crc_start  = crc_byte(CRC_INIT, crc_seed_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         report_id_ff  <= 8'd49;
         header_tag_ff <= 8'd16;
         crc_seed_ff   <= 8'd162;
         pos_ff        <= '0;
         seq_ff        <= '0;
      end else begin
         report_id_ff  <= report_id_in;
         header_tag_ff <= header_tag_in;
         crc_seed_ff   <= crc_seed_in;
         pos_ff        <= pos_in;
         seq_ff        <= seq_in;
      end
   end

endmodule

### hw/rtl/rfc_queue.sv
// Short register queue between the framer front and back.
// Depends on rfc_pkg and the assertion macro header.
`include "report_framer_crc32_unit_defines.svh"
module rfc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rfc_pkg::item_type          push_item,
   input  logic                       pop,
   output rfc_pkg::item_type          head_item,
   output rfc_pkg::queue_status_type  q_status
);
   import rfc_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_item      = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `RFC_ASSERT(a_q_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `RFC_ASSERT(a_q_no_overflow, !push || !q_status.full)
   `RFC_ASSERT(a_q_no_underflow, !pop || !q_status.empty)

endmodule

### hw/rtl/rfc_back.sv
// Back of the report framer: walks header, payload, padding and CRC trailer one
// byte per cycle into the output register unless rsp stalls. Depends on rfc_pkg and macros.
`include "report_framer_crc32_unit_defines.svh"
module rfc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  rfc_pkg::item_type           head_item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rfc_pkg::BYTE_W-1:0]  rsp_frame_byte,
   output logic                        rsp_run_end,
   output logic                        rsp_frame_end
);
   import rfc_pkg::*;

   localparam phase_type TAIL_PHASE = (PAD_LEN > 0) ? PH_PAD : PH_TRAILER;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_frame_byte_ff;
   logic              rsp_run_end_ff;
   logic              rsp_frame_end_ff;

   logic              advance;
   logic              work;
   phase_type         start_phase;
   phase_type         cur_phase;
   logic [CNT_W-1:0]  cur_cnt;
   phase_type         nxt_phase;
   logic [CNT_W-1:0]  nxt_cnt;
   logic              done;
   logic [BYTE_W-1:0] out_byte;
   logic              out_frame_end;
   logic              feed_crc;
   logic [CRC_W-1:0]  crc_base;
   logic [CRC_W-1:0]  crc_inv;

   // Output register frees when empty or taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign work    = head_valid && advance;
   assign pop     = work && done;

   // First phase of a fresh transaction
   always_comb begin
      if (head_item.first) begin
         start_phase = PH_HEADER;
      end else if (head_item.emit) begin
         start_phase = PH_PAYLOAD;
      end else if (head_item.last) begin
         start_phase = TAIL_PHASE;
      end else begin
         start_phase = PH_IDLE;
      end
   end

   assign cur_phase = (phase_ff == PH_IDLE) ? start_phase : phase_ff;
   assign cur_cnt   = (phase_ff == PH_IDLE) ? '0 : cnt_ff;

   // Next state
   always_comb begin
      nxt_phase = PH_IDLE;
      nxt_cnt   = '0;
      done      = 1'b0;
      case (cur_phase)
         PH_HEADER: begin
            if (cur_cnt == CNT_W'(2)) begin
               if (head_item.emit) begin
                  nxt_phase = PH_PAYLOAD;
               end else if (head_item.last) begin
                  nxt_phase = TAIL_PHASE;
               end else begin
                  done = 1'b1;
               end
            end else begin
               nxt_phase = PH_HEADER;
               nxt_cnt   = cur_cnt + 1'b1;
            end
         end
         PH_PAYLOAD: begin
            if (head_item.last) begin
               nxt_phase = TAIL_PHASE;
            end else begin
               done = 1'b1;
            end
         end
         PH_PAD: begin
            if (cur_cnt == CNT_W'(PAD_LAST)) begin
               nxt_phase = PH_TRAILER;
            end else begin
               nxt_phase = PH_PAD;
               nxt_cnt   = cur_cnt + 1'b1;
            end
         end
         PH_TRAILER: begin
            if (cur_cnt == CNT_W'(3)) begin
               done = 1'b1;
            end else begin
               nxt_phase = PH_TRAILER;
               nxt_cnt   = cur_cnt + 1'b1;
            end
         end
         default: done = 1'b1;
      endcase
   end

   // Outputs: frame byte and CRC feed
   assign crc_inv = ~crc_ff;
   always_comb begin
      out_byte      = '0;
      out_frame_end = 1'b0;
      feed_crc      = 1'b0;
      case (cur_phase)
         PH_HEADER: begin
            feed_crc = 1'b1;
            case (cur_cnt)
               CNT_W'(0): out_byte = head_item.report_id;
               CNT_W'(1): out_byte = {head_item.seq, {(BYTE_W-SEQ_W){1'b0}}};
               default:   out_byte = head_item.header_tag;
            endcase
         end
         PH_PAYLOAD: begin
            feed_crc = 1'b1;
            out_byte = head_item.data;
         end
         PH_PAD: begin
            feed_crc = 1'b1;
            out_byte = '0;
         end
         PH_TRAILER: begin
            case (cur_cnt[1:0])
               2'd0:    out_byte = crc_inv[7:0];
               2'd1:    out_byte = crc_inv[15:8];
               2'd2:    out_byte = crc_inv[23:16];
               default: out_byte = crc_inv[31:24];
            endcase
            out_frame_end = (cur_cnt == CNT_W'(3));
         end
         default: ;
      endcase
   end

   // Frame CRC starts from the seeded preset on the first header byte
   assign crc_base = (cur_phase == PH_HEADER && cur_cnt == '0) ?
                     head_item.crc_start : crc_ff;

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = work;
      end
      if (work) begin
         phase_in = done ? PH_IDLE : nxt_phase;
         cnt_in   = done ? '0 : nxt_cnt;
         if (feed_crc) begin
            crc_in = crc_byte(crc_base, out_byte);
         end else if (out_frame_end) begin
            crc_in = CRC_INIT;
         end
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (work) begin
         rsp_frame_byte_ff <= out_byte;
         rsp_run_end_ff    <= done;
         rsp_frame_end_ff  <= out_frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_run_end    = rsp_run_end_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

   `RFC_ASSERT(a_frame_end_ends_run, !rsp_valid_ff || !rsp_frame_end_ff || rsp_run_end_ff)
   `RFC_ASSERT(a_busy_has_head, (phase_ff == PH_IDLE) || head_valid)
   `RFC_ASSERT_NEXT(a_crc_rearm, work && out_frame_end, crc_ff == CRC_INIT)

endmodule

### hw/rtl/report_framer_crc32_unit.sv
// Top level of the report framer with CRC-32 trailer.
// Depends on rfc_pkg, rfc_front, rfc_queue and rfc_back.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_payload_byte
//   rsp      out        rsp_valid/stall    rsp_frame_byte, rsp_run_end, rsp_frame_end
//   csr      in         csr_write_en       csr_index, csr_data
//
// The back end sends one frame byte per cycle while rsp is not stalled: a transaction
// gives 1 frame byte for a plain payload byte, 4 for the first of a frame and
// 1+PAD_LEN+4 for the last (3+1+PAD_LEN+4 when the frame has a single payload byte);
// the CRC step is likewise one byte per cycle. The front takes one transaction per
// cycle while the 4-entry queue has room. Reset is synchronous and needs no clearing pass.
// A stalled rsp holds its byte; req stalls only while the queue is full.
module report_framer_crc32_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [rfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfc_pkg::BYTE_W-1:0]     csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rfc_pkg::BYTE_W-1:0]     req_payload_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rfc_pkg::BYTE_W-1:0]     rsp_frame_byte,
   output logic                           rsp_run_end,
   output logic                           rsp_frame_end
);
   import rfc_pkg::*;

   queue_status_type q_status;
   logic             push;
   item_type         push_item;
   logic             pop;
   item_type         head_item;

   rfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_payload_byte (req_payload_byte),
      .req_stall        (req_stall),
      .q_status         (q_status),
      .push             (push),
      .push_item        (push_item)
   );

   rfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   rfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!q_status.empty),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

### tb/tb_report_framer_crc32_unit.sv
// Self-checking testbench for report_framer_crc32_unit: drives payload bytes,
// predicts each framed byte with its own CRC-32 framer and compares every output.
// Depends on rfc_pkg and the report_framer_crc32_unit RTL.
module tb_report_framer_crc32_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rfc_pkg::*;

   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 8;
   localparam int FINAL_SETTLE   = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_FRAMES  = 5;
   localparam int MAX_REPORTED   = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_UNUSED = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              run_end;
      logic              frame_end;
   } frame_result_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 csr_write_en     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [BYTE_W-1:0]    csr_data         = '0;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_payload_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [BYTE_W-1:0]    rsp_frame_byte;
   logic                 rsp_run_end;
   logic                 rsp_frame_end;

   // Framer state mirrored by the testbench
   logic [BYTE_W-1:0] report_id_reg  = 8'd49;
   logic [BYTE_W-1:0] header_tag_reg = 8'd16;
   logic [BYTE_W-1:0] crc_seed_reg   = 8'd162;
   logic [SEQ_W-1:0]  next_seq       = '0;
   logic [CRC_W-1:0]  frame_crc      = CRC_INIT;
   logic [POS_W-1:0]  payload_count  = '0;

   frame_result_type pending_frame_bytes[$];
   frame_result_type step_bytes[$];

   int  fail_count    = 0;
   bit  idle_enable   = 1'b1;
   int  hold_request  = 0;
   int  hold_served   = 0;
   int  hold_left     = 0;
   int  stall_left    = 0;
   int  quiet_cycles  = 0;

   report_framer_crc32_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_run_end      (rsp_run_end),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Reflected CRC-32 update over one byte, LSB first
   function automatic logic [CRC_W-1:0] crc32_byte_step(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] value);
      logic [CRC_W-1:0] c;
      c = crc ^ CRC_W'(value);
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Mostly back-to-back, sometimes short gaps, rarely long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 11))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h01;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic void add_crc_byte(input logic [BYTE_W-1:0] value);
      frame_crc = crc32_byte_step(frame_crc, value);
      step_bytes.push_back('{frame_byte: value, run_end: 1'b0, frame_end: 1'b0});
   endfunction

   // Work out the frame bytes one payload byte causes and queue them
   function automatic void frame_payload_byte(input logic [BYTE_W-1:0] value);
      logic [CRC_W-1:0] trailer;
      frame_result_type last_one;
      step_bytes.delete();
      if (payload_count == 0) begin
         frame_crc = crc32_byte_step(CRC_INIT, crc_seed_reg);
         add_crc_byte(report_id_reg);
         add_crc_byte({next_seq, 4'h0});
         add_crc_byte(header_tag_reg);
         next_seq = next_seq + 1'b1;
      end
      if (int'(payload_count) < PAYLOAD_ROOM) begin
         add_crc_byte(value);
      end
      payload_count = payload_count + 1'b1;
      if (int'(payload_count) >= PAYLOAD_LEN) begin
         for (int i = 3 + PAYLOAD_LEN; i < DATA_LEN; i++) begin
            add_crc_byte(8'h00);
         end
         trailer = ~frame_crc;
         for (int k = 0; k < 4; k++) begin
            step_bytes.push_back('{frame_byte: trailer[8*k +: 8], run_end: 1'b0,
                                   frame_end: (k == 3)});
         end
         frame_crc     = CRC_INIT;
         payload_count = '0;
      end
      if (step_bytes.size() > 0) begin
         last_one         = step_bytes.pop_back();
         last_one.run_end = 1'b1;
         step_bytes.push_back(last_one);
      end
      foreach (step_bytes[i]) begin
         pending_frame_bytes.push_back(step_bytes[i]);
      end
   endfunction

   // Offer one payload byte, hold it until accepted, then predict
   task automatic send_payload(input logic [BYTE_W-1:0] value);
      int gap;
      gap = idle_enable ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      frame_payload_byte(value);
   endtask

   task automatic send_random_bytes(input int count);
      for (int i = 0; i < count; i++) begin
         send_payload(pick_byte());
      end
   endtask

   // Drop valid and wait until every predicted byte has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; program_registers closes the burst
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [BYTE_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= value;
      @(posedge clock);
      case (index)
         CSR_REPORT_ID:  report_id_reg  = value;
         CSR_HEADER_TAG: header_tag_reg = value;
         CSR_CRC_SEED:   crc_seed_reg   = value;
         default: ;
      endcase
   endtask

   task automatic program_registers(input logic [BYTE_W-1:0] id,
                                    input logic [BYTE_W-1:0] tag,
                                    input logic [BYTE_W-1:0] seed);
      write_register(CSR_REPORT_ID, id);
      write_register(CSR_HEADER_TAG, tag);
      write_register(CSR_CRC_SEED, seed);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Reset values, byte extremes, and a register write in the middle of a frame
   task automatic test_default_frame();
      logic [BYTE_W-1:0] directed[$];
      directed = {8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                  8'h0F, 8'hF0, 8'h33, 8'hCC};
      foreach (directed[i]) begin
         send_payload(directed[i]);
      end
      wait_drained();
      // Header and CRC seed of this frame were taken already; new values wait
      program_registers(rand_byte(), rand_byte(), rand_byte());
      send_random_bytes(PAYLOAD_LEN - directed.size());
      wait_drained();
   endtask

   // Register extremes and a write to the unused index
   task automatic test_register_extremes();
      program_registers(8'h00, 8'h00, 8'h00);
      send_random_bytes(PAYLOAD_LEN);
      wait_drained();
      write_register(CSR_INDEX_UNUSED, rand_byte());
      program_registers(8'hFF, 8'hFF, 8'hFF);
      send_random_bytes(PAYLOAD_LEN);
      wait_drained();
   endtask

   // Hold off the output while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      idle_enable = 1'b0;
      hold_request++;
      send_random_bytes(PAYLOAD_LEN);
      wait_drained();
      idle_enable = 1'b1;
   endtask

   // Whole frames with random content and settings
   task automatic test_random_frames();
      int split;
      for (int f = 0; f < RANDOM_FRAMES; f++) begin
         idle_enable = (f % 4 != 3);
         if ($urandom_range(0, 1) == 0) begin
            program_registers(rand_byte(), rand_byte(), rand_byte());
         end
         if ($urandom_range(0, 2) == 0) begin
            split = $urandom_range(1, PAYLOAD_LEN - 1);
            send_random_bytes(split);
            wait_drained();
            program_registers(rand_byte(), rand_byte(), rand_byte());
            send_random_bytes(PAYLOAD_LEN - split);
         end else begin
            send_random_bytes(PAYLOAD_LEN);
         end
         wait_drained();
      end
      idle_enable = 1'b1;
   endtask

   // Output stall: long hold on request, else random stall runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request != hold_served) begin
         hold_served = hold_request;
         hold_left   = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each output transaction with the oldest predicted byte
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_frame_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTED) begin
               $display("unexpected output: byte %02h run_end %b frame_end %b",
                        rsp_frame_byte, rsp_run_end, rsp_frame_end);
            end
         end else begin
            want = pending_frame_bytes.pop_front();
            if (rsp_frame_byte !== want.frame_byte || rsp_run_end !== want.run_end ||
                rsp_frame_end !== want.frame_end) begin
               fail_count++;
               if (fail_count <= MAX_REPORTED) begin
                  $display("mismatch: expected byte %02h run_end %b frame_end %b, %s",
                           want.frame_byte, want.run_end, want.frame_end, "got");
                  $display("          byte %02h run_end %b frame_end %b",
                           rsp_frame_byte, rsp_run_end, rsp_frame_end);
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall) || csr_write_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("** report_framer_crc32_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_frame();
      test_register_extremes();
      test_backpressure();
      test_random_frames();
      wait_drained();
      repeat (FINAL_SETTLE) @(posedge clock);
      if (pending_frame_bytes.size() != 0) begin
         $display("%0d predicted bytes never came out", pending_frame_bytes.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("** report_framer_crc32_unit: PASSED **");
      end else begin
         $display("** report_framer_crc32_unit: FAILED **");
      end
      $finish;
   end

endmodule
